// ===== sv/sbbc_pkg.sv =====
// Shared types and constants for the swept box brush clipper.
`default_nettype none
package sbbc_pkg;
  localparam int COORD_BITS = 20;
  localparam int NORM_BITS  = 16;
  localparam int NORM_FRAC  = 14;
  localparam int REG_BITS   = 60;
  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START = 2'd0,
    CFG_END   = 2'd1,
    CFG_MINS  = 2'd2,
    CFG_MAXS  = 2'd3
  } cfg_idx_t;
endpackage
`default_nettype wire

// ===== sv/swept_box_brush_clip.sv =====
// Swept box clipper top level: sequenced dot products and shared divider.
//
// Usage: set start_xyz, end_xyz, box_mins_xyz and box_maxs_xyz through the
// cfg_ write channel (cfg_index selects the register, cfg_wdata the value)
// while idle. Stream words on the in_ channel: kind 0 starts a new trace,
// kind 1 carries one brush side. A side flagged last_side yields one out_
// word with the running best fraction, solid flags and best hit identity.
// Each side runs through a sequencer: the accept step, multiply-accumulate
// over the x, y and z axes for the corner offset and both endpoint distances,
// an evaluate step, FRACTION_BITS steps of a restoring divider, an update and
// a finish step. A last side then passes an output state that loads the
// output word, which leaves once out_stall is low. Skipped sides go from
// accept straight to finish, missing sides skip the divider, and saturated
// fractions skip its bit steps. A new trace word is handled in the accept
// step alone. in_stall stays high while a side is at work or while a
// result waits in the output register; out_stall holds that word. Reset
// (rst_n low, synchronous) clears the registers to zero, the best fraction
// to 1.0, the hit surface to -1, and empties the output.
`default_nettype none
module swept_box_brush_clip #(
  parameter int COORD_FRAC_BITS = 6,
  parameter int FRACTION_BITS   = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sbbc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [sbbc_pkg::REG_BITS-1:0]     cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_kind,
  input  wire logic signed [15:0]                in_normal_x,
  input  wire logic signed [15:0]                in_normal_y,
  input  wire logic signed [15:0]                in_normal_z,
  input  wire logic signed [19:0]                in_plane_dist,
  input  wire logic                              in_is_bevel,
  input  wire logic [15:0]                       in_plane_index,
  input  wire logic signed [15:0]                in_tex_info,
  input  wire logic [31:0]                       in_brush_contents,
  input  wire logic                              in_first_side,
  input  wire logic                              in_last_side,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [FRACTION_BITS:0]                 out_fraction,
  output logic                                   out_brush_hit,
  output logic                                   out_start_solid,
  output logic                                   out_all_solid,
  output logic [15:0]                            out_hit_plane_index,
  output logic signed [15:0]                     out_hit_tex_info,
  output logic [31:0]                            out_hit_contents
);
  import sbbc_pkg::*;

  localparam int FB   = FRACTION_BITS;
  localparam int FW   = FB + 2;             // signed side fraction
  localparam int DW   = 40;                 // distance accumulator
  localparam int MAGW = DW;                 // magnitude width
  localparam int QW   = FB + 1;
  localparam int CNTW = $clog2(QW + 1);
  localparam logic [DW-1:0] MARGIN = DW'(1) << (COORD_FRAC_BITS + NORM_FRAC - 5);
  localparam logic signed [FW-1:0] ONE = FW'(1) << FB;

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_EVAL, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  logic [REG_BITS-1:0] start_r, end_r, mins_r, maxs_r;

  // latched side
  logic signed [15:0] nrm_r [3];
  logic [15:0] pidx_r;
  logic [15:0] tex_r;
  logic [31:0] cont_r;
  logic last_r;

  logic [1:0] ax_r;
  logic signed [DW-1:0] dist_r, d1_r, d2_r;
  logic neg_r, enter_r;
  logic [MAGW-1:0] rem_r;
  logic [MAGW-1:0] dv_r;
  logic [QW-1:0] q_r;
  logic [CNTW-1:0] cnt_r;

  // trace/brush state
  logic [FB:0] best_frac_r;
  logic [15:0] best_plane_r, best_tex_r;
  logic [31:0] best_cont_r;
  logic [1:0] solid_r;
  logic signed [FW-1:0] enter_f_r, leave_f_r;
  logic enter_v_r;
  logic [15:0] enter_plane_r, enter_tex_r;
  logic [2:0] bflags_r;

  logic point;
  assign point = (mins_r == '0) && (maxs_r == '0);

  assign cfg_ready = (state_r == S_IDLE) && !out_valid;
  assign in_stall  = !((state_r == S_IDLE) && !out_valid);

  // shared multiplier operands
  logic signed [15:0] mn;
  logic signed [19:0] cs, ce, cb;
  logic signed [35:0] ps, pe, pb;
  always_comb begin
    mn = nrm_r[ax_r];
    cs = start_r[ax_r*COORD_BITS +: COORD_BITS];
    ce = end_r[ax_r*COORD_BITS +: COORD_BITS];
    cb = mn[15] ? maxs_r[ax_r*COORD_BITS +: COORD_BITS]
                : mins_r[ax_r*COORD_BITS +: COORD_BITS];
    ps = cs * mn;
    pe = ce * mn;
    pb = cb * mn;
  end

  logic signed [DW-1:0] e1, e2, dnum, dden;
  logic [MAGW-1:0] unum, uden;
  always_comb begin
    e1 = d1_r - dist_r;
    e2 = d2_r - dist_r;
    dden = e1 - e2;
    dnum = (e1 > e2) ? e1 - $signed(MARGIN) : e1 + $signed(MARGIN);
    unum = dnum[DW-1] ? MAGW'(-dnum) : MAGW'(dnum);
    uden = dden[DW-1] ? MAGW'(-dden) : MAGW'(dden);
  end

  logic [MAGW:0] trial;
  assign trial = {rem_r, 1'b0} - {1'b0, dv_r};

  logic signed [FW-1:0] fside;
  always_comb begin
    logic [QW-1:0] qs;
    qs = (q_r > QW'(ONE)) ? QW'(ONE) : q_r;
    fside = neg_r ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
  end

  logic hit;
  always_comb begin
    hit = !bflags_r[2] && bflags_r[1] && enter_v_r && (enter_f_r < leave_f_r)
          && (enter_f_r < $signed({1'b0, best_frac_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= '0; end_r <= '0; mins_r <= '0; maxs_r <= '0;
      out_valid <= 1'b0;
      best_frac_r <= (FB+1)'(ONE);
      best_plane_r <= '0; best_tex_r <= '1; best_cont_r <= '0; solid_r <= '0;
      enter_f_r <= '0; enter_v_r <= 1'b0; leave_f_r <= ONE;
      enter_plane_r <= '0; enter_tex_r <= '1; bflags_r <= '0;
      ax_r <= '0; cnt_r <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_START: start_r <= cfg_wdata;
          CFG_END:   end_r <= cfg_wdata;
          CFG_MINS:  mins_r <= cfg_wdata;
          CFG_MAXS:  maxs_r <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            if (!in_kind) begin
              best_frac_r <= (FB+1)'(ONE);
              best_plane_r <= '0; best_tex_r <= '1; best_cont_r <= '0;
              solid_r <= '0;
              enter_f_r <= '0; enter_v_r <= 1'b0; leave_f_r <= ONE;
              enter_plane_r <= '0; enter_tex_r <= '1; bflags_r <= '0;
            end else begin
              nrm_r[0] <= in_normal_x; nrm_r[1] <= in_normal_y;
              nrm_r[2] <= in_normal_z;
              pidx_r <= in_plane_index;
              tex_r <= in_tex_info; cont_r <= in_brush_contents;
              last_r <= in_last_side;
              dist_r <= DW'(in_plane_dist) <<< NORM_FRAC;
              d1_r <= '0; d2_r <= '0; ax_r <= '0;
              if (in_first_side) begin
                enter_f_r <= '0; enter_v_r <= 1'b0; leave_f_r <= ONE;
                enter_plane_r <= '0; enter_tex_r <= '1; bflags_r <= '0;
              end
              if ((in_first_side || !bflags_r[2]) && !(point && in_is_bevel))
                state_r <= S_MAC;
              else
                state_r <= S_FIN;
            end
          end
        end
        S_MAC: begin
          if (!point) dist_r <= dist_r - DW'(pb);
          d1_r <= d1_r + DW'(ps);
          d2_r <= d2_r + DW'(pe);
          ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
          if (ax_r == 2'd2) state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (e1 > 0 && e2 > 0) begin
            bflags_r[2] <= 1'b1;
            state_r <= S_FIN;
          end else begin
            if (e2 > 0) bflags_r[0] <= 1'b1;
            if (e1 > 0) bflags_r[1] <= 1'b1;
            if (e1 > 0 || e2 > 0) begin
              enter_r <= e1 > e2;
              neg_r <= dnum[DW-1] ^ dden[DW-1];
              rem_r <= unum;
              dv_r <= uden;
              // numerator at least the divisor saturates to one
              if (unum >= uden) begin
                q_r <= QW'(ONE);
                cnt_r <= '0;
              end else begin
                q_r <= '0;
                cnt_r <= CNTW'(FB);
              end
              state_r <= S_DIV;
            end else state_r <= S_FIN;
          end
        end
        S_DIV: begin
          // restoring long division, one quotient bit per cycle, MSB first
          if (cnt_r != '0) begin
            if (!trial[MAGW]) begin
              rem_r <= trial[MAGW-1:0];
              q_r <= {q_r[QW-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[MAGW-2:0], 1'b0};
              q_r <= {q_r[QW-2:0], 1'b0};
            end
            cnt_r <= cnt_r - 1'b1;
          end else begin
            if (enter_r) begin
              if (!enter_v_r || fside > enter_f_r) begin
                enter_f_r <= fside; enter_v_r <= 1'b1;
                enter_plane_r <= pidx_r; enter_tex_r <= tex_r;
              end
            end else if (fside < leave_f_r) leave_f_r <= fside;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (last_r) state_r <= S_OUT;
          else state_r <= S_IDLE;
        end
        S_OUT: begin
          out_brush_hit <= hit;
          if (!bflags_r[2] && !bflags_r[1]) begin
            solid_r[0] <= 1'b1;
            if (!bflags_r[0]) solid_r[1] <= 1'b1;
          end
          if (hit) begin
            best_frac_r <= enter_f_r[FW-1] ? '0 : enter_f_r[FB:0];
            best_plane_r <= enter_plane_r; best_tex_r <= enter_tex_r;
            best_cont_r <= cont_r;
          end
          enter_f_r <= '0; enter_v_r <= 1'b0; leave_f_r <= ONE;
          enter_plane_r <= '0; enter_tex_r <= '1; bflags_r <= '0;
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_fraction = best_frac_r;
  assign out_start_solid = solid_r[0];
  assign out_all_solid = solid_r[1];
  assign out_hit_plane_index = best_plane_r;
  assign out_hit_tex_info = best_tex_r;
  assign out_hit_contents = best_cont_r;
endmodule
`default_nettype wire
